[rtl/pehe_pkg.sv]
// Package for the polyline heading estimator: widths, codes, controller/datapath
// structs, the job table and the CORDIC arctangent table.
// No dependencies.
`default_nettype none

package pehe_pkg;

	localparam int COORD_WIDTH   = 32;
	localparam int HEADING_WIDTH = 16;
	localparam int CORDIC_STEPS  = 16;
	localparam int ITER_W        = $clog2(CORDIC_STEPS + 1);
	localparam int ANG_W         = 32;
	// difference vector after CORDIC gain fits with a few guard bits
	localparam int CORD_W        = COORD_WIDTH + 4;
	localparam int PS_W          = 3;
	localparam int JOB_W         = 3;

	localparam logic [PS_W-1:0]  PS_EMPTY  = PS_W'(0);
	localparam logic [PS_W-1:0]  PS_FULL   = PS_W'(3);
	localparam logic [PS_W-1:0]  PS_STREAM = PS_W'(4);
	localparam logic [ANG_W-1:0] ANG_HALF_PI2 = ANG_W'(1) << (ANG_W - 1);
	localparam logic [ANG_W-1:0] ANG_RND   = ANG_W'(1) << (ANG_W - 1 - HEADING_WIDTH);

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [COORD_WIDTH:0]   diff_t;
	typedef logic signed [CORD_W-1:0]      cord_t;
	typedef logic [HEADING_WIDTH-1:0]      heading_t;
	typedef logic [ANG_W-1:0]              angle_t;

	typedef enum logic [1:0] {
		SLOT_B0,
		SLOT_B1,
		SLOT_B2,
		SLOT_CUR
	} slot_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_LOAD,
		S_START,
		S_WAIT,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic  valid;
		logic  calc;
		slot_t pt;
		slot_t a;
		slot_t b;
		logic  last;
	} job_t;

	typedef struct packed {
		logic            take;
		logic            load_diff;
		logic            cordic_start;
		logic            emit;
		logic            update;
		job_t            job;
		logic [PS_W-1:0] ps;
	} cmd_t;

	typedef struct packed {
		logic cur_last;
		logic cordic_done;
		logic out_free;
	} stat_t;

	// j-th result for a request taken with ps points already held
	function automatic job_t job_of(input logic [PS_W-1:0] ps, input logic last,
			input logic [JOB_W-1:0] j);
		job_t r;
		r.valid = 1'b0;
		r.calc  = 1'b0;
		r.pt    = SLOT_B0;
		r.a     = SLOT_B0;
		r.b     = SLOT_B0;
		r.last  = 1'b0;
		if (ps < PS_FULL) begin
			// short path: flush held points with their own headings
			if (last) begin
				if (j < JOB_W'(ps)) begin
					r.valid = 1'b1;
					r.pt    = slot_t'(j[1:0]);
				end else if (j == JOB_W'(ps)) begin
					r.valid = 1'b1;
					r.pt    = SLOT_CUR;
					r.last  = 1'b1;
				end
			end
		end else if (ps == PS_FULL) begin
			case (j)
				JOB_W'(0): begin
					r.valid = 1'b1; r.calc = 1'b1;
					r.pt = SLOT_B0; r.a = SLOT_B0; r.b = SLOT_B1;
				end
				JOB_W'(1): begin
					r.valid = 1'b1; r.calc = 1'b1;
					r.pt = SLOT_B1; r.a = SLOT_B0; r.b = SLOT_B2;
				end
				JOB_W'(2): begin
					r.valid = 1'b1; r.calc = 1'b1;
					r.pt = SLOT_B2; r.a = SLOT_B1; r.b = SLOT_CUR;
				end
				JOB_W'(3): begin
					r.valid = last; r.calc = 1'b1; r.last = 1'b1;
					r.pt = SLOT_CUR; r.a = SLOT_B2; r.b = SLOT_CUR;
				end
				default: r.valid = 1'b0;
			endcase
		end else begin
			case (j)
				JOB_W'(0): begin
					r.valid = 1'b1; r.calc = 1'b1;
					r.pt = SLOT_B1; r.a = SLOT_B0; r.b = SLOT_CUR;
				end
				JOB_W'(1): begin
					r.valid = last; r.calc = 1'b1; r.last = 1'b1;
					r.pt = SLOT_CUR; r.a = SLOT_B1; r.b = SLOT_CUR;
				end
				default: r.valid = 1'b0;
			endcase
		end
		return r;
	endfunction

	// atan(2^-i) as a fraction of a turn, 2^32 = full turn
	function automatic angle_t atan_turn(input logic [ITER_W-1:0] i);
		angle_t r;
		case (i)
			ITER_W'(0):  r = 32'd536870912;
			ITER_W'(1):  r = 32'd316933406;
			ITER_W'(2):  r = 32'd167458907;
			ITER_W'(3):  r = 32'd85004756;
			ITER_W'(4):  r = 32'd42667331;
			ITER_W'(5):  r = 32'd21354465;
			ITER_W'(6):  r = 32'd10679838;
			ITER_W'(7):  r = 32'd5340245;
			ITER_W'(8):  r = 32'd2670163;
			ITER_W'(9):  r = 32'd1335087;
			ITER_W'(10): r = 32'd667544;
			ITER_W'(11): r = 32'd333772;
			ITER_W'(12): r = 32'd166886;
			ITER_W'(13): r = 32'd83443;
			ITER_W'(14): r = 32'd41722;
			ITER_W'(15): r = 32'd20861;
			ITER_W'(16): r = 32'd10430;
			ITER_W'(17): r = 32'd5215;
			ITER_W'(18): r = 32'd2608;
			ITER_W'(19): r = 32'd1304;
			ITER_W'(20): r = 32'd652;
			ITER_W'(21): r = 32'd326;
			ITER_W'(22): r = 32'd163;
			ITER_W'(23): r = 32'd81;
			default:     r = 32'd0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

[rtl/pehe_in_if.sv]
// Input point channel: valid/ready plus point payload.
// Depends on pehe_pkg.
`default_nettype none

interface pehe_in_if;
	logic                       valid;
	logic                       ready;
	pehe_pkg::coord_t           east_pos;
	pehe_pkg::coord_t           north_pos;
	pehe_pkg::heading_t         heading_in;
	logic                       path_end;

	modport source (output valid, output east_pos, output north_pos, output heading_in,
		output path_end, input ready);
	modport sink (input valid, input east_pos, input north_pos, input heading_in,
		input path_end, output ready);
endinterface

`default_nettype wire

[rtl/pehe_out_if.sv]
// Output point channel: valid/ready plus point payload with computed heading.
// Depends on pehe_pkg.
`default_nettype none

interface pehe_out_if;
	logic                       valid;
	logic                       ready;
	pehe_pkg::coord_t           east_out;
	pehe_pkg::coord_t           north_out;
	pehe_pkg::heading_t         heading_out;
	logic                       out_last;

	modport source (output valid, output east_out, output north_out, output heading_out,
		output out_last, input ready);
	modport sink (input valid, input east_out, input north_out, input heading_out,
		input out_last, output ready);
endinterface

`default_nettype wire

[rtl/polyline_heading_estimator.sv]
// Top level of the polyline heading estimator: controller plus datapath.
// Depends on pehe_pkg, pehe_in_if, pehe_out_if, pehe_ctrl, pehe_dp.
//
//   channel  | dir | payload                                      | handshake
//   in_ch    | in  | east_pos, north_pos, heading_in, path_end    | valid/ready
//   out_ch   | out | east_out, north_out, heading_out, out_last   | valid/ready
//
// One request at a time, taken only in idle; a request passes idle and a final dispatch,
// each passed-through point a dispatch and an emit, and each computed heading dispatch,
// diff load, CORDIC start, 16 iterations, rounding, done and emit; the CORDIC loop dominates.
// Up to 4 results per request. Reset clears the controller, point count and output
// valid; no clearing pass. A stalled output holds the controller in its emit state.
`default_nettype none

module polyline_heading_estimator (
	input  wire         clk,
	input  wire         arst_n,
	pehe_in_if.sink     in_ch,
	pehe_out_if.source  out_ch
);
	import pehe_pkg::*;

	cmd_t  cmd;
	stat_t stat;
	logic  in_ready;

	assign in_ch.ready = in_ready;

	pehe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	pehe_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.east_pos    (in_ch.east_pos),
		.north_pos   (in_ch.north_pos),
		.heading_in  (in_ch.heading_in),
		.path_end    (in_ch.path_end),
		.out_valid   (out_ch.valid),
		.out_ready   (out_ch.ready),
		.east_out    (out_ch.east_out),
		.north_out   (out_ch.north_out),
		.heading_out (out_ch.heading_out),
		.out_last    (out_ch.out_last)
	);

	// never overwrite a result that has not been taken
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> stat.out_free)
		else $error("emit into a full output register");

	a_cordic_latency: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cordic_start |=> !stat.cordic_done)
		else $error("CORDIC finished too early");

	a_take_alone: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |-> !(cmd.emit || cmd.cordic_start || cmd.update || cmd.load_diff))
		else $error("request taken while work in flight");

	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		stat.cordic_done |-> !in_ready)
		else $error("ready raised while the CORDIC is running");

endmodule

`default_nettype wire

[rtl/pehe_cordic.sv]
// Iterative vectoring CORDIC: heading of (y, x) as a fraction of a turn,
// one micro-rotation per cycle. Depends on pehe_pkg.
`default_nettype none

module pehe_cordic (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  start,
	input  pehe_pkg::diff_t      dx,
	input  pehe_pkg::diff_t      dy,
	output logic                 done,
	output pehe_pkg::heading_t   heading
);
	import pehe_pkg::*;

	cord_t               x_q, y_q, xs, ys;
	angle_t              z_q, z_rnd;
	logic [ITER_W-1:0]   i_q;
	logic                run_q, zero_q, done_q;
	heading_t            heading_q;

	assign xs    = x_q >>> i_q;
	assign ys    = y_q >>> i_q;
	assign z_rnd = z_q + ANG_RND;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				i_q   <= '0;
			end else if (run_q) begin
				if (i_q == ITER_W'(CORDIC_STEPS)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					i_q <= i_q + ITER_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			// fold the left half-plane onto the right one
			zero_q <= (dx == '0) && (dy == '0);
			if (dx < 0) begin
				x_q <= -cord_t'(dx);
				y_q <= -cord_t'(dy);
				z_q <= ANG_HALF_PI2;
			end else begin
				x_q <= cord_t'(dx);
				y_q <= cord_t'(dy);
				z_q <= '0;
			end
		end else if (run_q) begin
			if (i_q == ITER_W'(CORDIC_STEPS)) begin
				heading_q <= zero_q ? heading_t'(0) : z_rnd[ANG_W-1 -: HEADING_WIDTH];
			end else if (y_q > 0) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan_turn(i_q);
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan_turn(i_q);
			end
		end
	end

	assign done    = done_q;
	assign heading = heading_q;

endmodule

`default_nettype wire

[rtl/pehe_dp.sv]
// Datapath: current point, three-point buffer, difference registers, CORDIC
// and the output register. Depends on pehe_pkg and pehe_cordic.
`default_nettype none

module pehe_dp (
	input  wire                  clk,
	input  wire                  arst_n,
	input  pehe_pkg::cmd_t       cmd,
	output pehe_pkg::stat_t      stat,
	input  pehe_pkg::coord_t     east_pos,
	input  pehe_pkg::coord_t     north_pos,
	input  pehe_pkg::heading_t   heading_in,
	input  wire                  path_end,
	output logic                 out_valid,
	input  wire                  out_ready,
	output pehe_pkg::coord_t     east_out,
	output pehe_pkg::coord_t     north_out,
	output pehe_pkg::heading_t   heading_out,
	output logic                 out_last
);
	import pehe_pkg::*;

	coord_t   cur_e_q, cur_n_q;
	heading_t cur_h_q;
	logic     cur_last_q;
	coord_t   buf_e_q [3];
	coord_t   buf_n_q [3];
	heading_t buf_h_q [3];
	diff_t    dx_q, dy_q;
	logic     ov_q;
	coord_t   oe_q, on_q;
	heading_t oh_q;
	logic     ol_q;
	logic     cord_done;
	heading_t cord_heading;

	coord_t   pt_e, pt_n, a_e, a_n, b_e, b_n;
	heading_t pt_h;

	always_comb begin
		case (cmd.job.pt)
			SLOT_B0: begin pt_e = buf_e_q[0]; pt_n = buf_n_q[0]; pt_h = buf_h_q[0]; end
			SLOT_B1: begin pt_e = buf_e_q[1]; pt_n = buf_n_q[1]; pt_h = buf_h_q[1]; end
			SLOT_B2: begin pt_e = buf_e_q[2]; pt_n = buf_n_q[2]; pt_h = buf_h_q[2]; end
			default: begin pt_e = cur_e_q;    pt_n = cur_n_q;    pt_h = cur_h_q;    end
		endcase
		case (cmd.job.a)
			SLOT_B0: begin a_e = buf_e_q[0]; a_n = buf_n_q[0]; end
			SLOT_B1: begin a_e = buf_e_q[1]; a_n = buf_n_q[1]; end
			SLOT_B2: begin a_e = buf_e_q[2]; a_n = buf_n_q[2]; end
			default: begin a_e = cur_e_q;    a_n = cur_n_q;    end
		endcase
		case (cmd.job.b)
			SLOT_B0: begin b_e = buf_e_q[0]; b_n = buf_n_q[0]; end
			SLOT_B1: begin b_e = buf_e_q[1]; b_n = buf_n_q[1]; end
			SLOT_B2: begin b_e = buf_e_q[2]; b_n = buf_n_q[2]; end
			default: begin b_e = cur_e_q;    b_n = cur_n_q;    end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			cur_e_q    <= east_pos;
			cur_n_q    <= north_pos;
			cur_h_q    <= heading_in;
			cur_last_q <= path_end;
		end
		if (cmd.load_diff) begin
			dy_q <= diff_t'(b_e) - diff_t'(a_e);
			dx_q <= diff_t'(b_n) - diff_t'(a_n);
		end
		if (cmd.update) begin
			if (cmd.ps < PS_FULL) begin
				if (!cur_last_q) begin
					buf_e_q[cmd.ps[1:0]] <= cur_e_q;
					buf_n_q[cmd.ps[1:0]] <= cur_n_q;
					buf_h_q[cmd.ps[1:0]] <= cur_h_q;
				end
			end else begin
				// slide: the pending point becomes the previous one
				if (cmd.ps == PS_FULL) begin
					buf_e_q[0] <= buf_e_q[2];
					buf_n_q[0] <= buf_n_q[2];
					buf_h_q[0] <= buf_h_q[2];
				end else begin
					buf_e_q[0] <= buf_e_q[1];
					buf_n_q[0] <= buf_n_q[1];
					buf_h_q[0] <= buf_h_q[1];
				end
				if (!cur_last_q) begin
					buf_e_q[1] <= cur_e_q;
					buf_n_q[1] <= cur_n_q;
					buf_h_q[1] <= cur_h_q;
				end
			end
		end
		if (cmd.emit) begin
			oe_q <= pt_e;
			on_q <= pt_n;
			oh_q <= cmd.job.calc ? cord_heading : pt_h;
			ol_q <= cmd.job.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (cmd.emit) begin
			ov_q <= 1'b1;
		end else if (out_ready) begin
			ov_q <= 1'b0;
		end
	end

	pehe_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.cordic_start),
		.dx      (dx_q),
		.dy      (dy_q),
		.done    (cord_done),
		.heading (cord_heading)
	);

	assign stat.cur_last    = cur_last_q;
	assign stat.cordic_done = cord_done;
	assign stat.out_free    = !ov_q || out_ready;

	assign out_valid   = ov_q;
	assign east_out    = oe_q;
	assign north_out   = on_q;
	assign heading_out = oh_q;
	assign out_last    = ol_q;

endmodule

`default_nettype wire

[rtl/pehe_ctrl.sv]
// Controller: takes a request, walks its result list, runs the CORDIC per
// computed heading, then updates the point buffer. Depends on pehe_pkg.
`default_nettype none

module pehe_ctrl (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_ready,
	input  pehe_pkg::stat_t    stat,
	output pehe_pkg::cmd_t     cmd
);
	import pehe_pkg::*;

	state_t            state_q, state_d;
	logic [PS_W-1:0]   ps_q;
	logic [JOB_W-1:0]  j_q;
	job_t              job;

	assign job = job_of(ps_q, stat.cur_last, j_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:     if (in_valid) state_d = S_DISPATCH;
			S_DISPATCH: begin
				if (!job.valid)    state_d = S_IDLE;
				else if (job.calc) state_d = S_LOAD;
				else               state_d = S_EMIT;
			end
			S_LOAD:     state_d = S_START;
			S_START:    state_d = S_WAIT;
			S_WAIT:     if (stat.cordic_done) state_d = S_EMIT;
			S_EMIT:     if (stat.out_free) state_d = S_DISPATCH;
			default:    state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd              = '0;
		cmd.job          = job;
		cmd.ps           = ps_q;
		in_ready         = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.take = in_valid;
			end
			S_DISPATCH: cmd.update       = !job.valid;
			S_LOAD:     cmd.load_diff    = 1'b1;
			S_START:    cmd.cordic_start = 1'b1;
			S_EMIT:     cmd.emit         = stat.out_free;
			default:    cmd.take         = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ps_q    <= PS_EMPTY;
			j_q     <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE) begin
				j_q <= '0;
			end
			if (state_q == S_EMIT && stat.out_free) begin
				j_q <= j_q + JOB_W'(1);
			end
			if (state_q == S_DISPATCH && !job.valid) begin
				if (stat.cur_last)       ps_q <= PS_EMPTY;
				else if (ps_q < PS_FULL) ps_q <= ps_q + PS_W'(1);
				else                     ps_q <= PS_STREAM;
			end
		end
	end

endmodule

`default_nettype wire

[tb/pehe_checker.sv]
// Scoreboard for the polyline heading estimator: watches both point channels,
// predicts the output points of every accepted request and compares them.
// Depends on pehe_pkg, pehe_in_if and pehe_out_if.

module pehe_checker
	import pehe_pkg::*;
(
	input  wire  clk,
	input  wire  arst_n,
	pehe_in_if   in_ch,
	pehe_out_if  out_ch,
	output int   fails,
	output int   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		coord_t   east;
		coord_t   north;
		heading_t heading;
		logic     last;
	} point_t;

	// atan(2^-i) in units of 2^-32 turn
	localparam angle_t ATAN_STEP [0:23] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81
	};

	point_t   expected_pts[$];
	coord_t   east_held[3];
	coord_t   north_held[3];
	heading_t head_held[3];
	int       held = 0;
	int       fail_count = 0;
	int       pending_r = 0;

	assign fails   = fail_count;
	assign pending = pending_r;

	// heading of the vector from (e0,n0) to (e1,n1), vectoring CORDIC
	function automatic heading_t bearing_code(input coord_t e0, input coord_t n0,
			input coord_t e1, input coord_t n1);
		longint dy, dx, sx, sy;
		angle_t acc;
		logic [ANG_W:0] rnd;
		int i;
		dy  = longint'(e1) - longint'(e0);
		dx  = longint'(n1) - longint'(n0);
		acc = '0;
		if (dx == 0 && dy == 0)
			return '0;
		// left half plane: rotate by a half turn first
		if (dx < 0) begin
			dx  = -dx;
			dy  = -dy;
			acc = 32'h8000_0000;
		end
		for (i = 0; i < CORDIC_STEPS && i < 24; i++) begin
			sx = dx >>> i;
			sy = dy >>> i;
			if (dy > 0) begin
				dx  = dx + sy;
				dy  = dy - sx;
				acc = acc + ATAN_STEP[i];
			end else begin
				dx  = dx - sy;
				dy  = dy + sx;
				acc = acc - ATAN_STEP[i];
			end
		end
		rnd = {1'b0, acc} + ((ANG_W + 1)'(1) << (ANG_W - 1 - HEADING_WIDTH));
		return rnd[ANG_W-1 -: HEADING_WIDTH];
	endfunction

	task automatic queue_point(input coord_t e, input coord_t n, input heading_t h,
			input logic last);
		point_t p;
		p.east    = e;
		p.north   = n;
		p.heading = h;
		p.last    = last;
		expected_pts.push_back(p);
	endtask

	task automatic track_point(input coord_t e, input coord_t n, input heading_t h,
			input logic last);
		int i;
		if (held < 3) begin
			if (last) begin
				// short path: held points keep their own headings
				for (i = 0; i < held; i++)
					queue_point(east_held[i], north_held[i], head_held[i], 1'b0);
				queue_point(e, n, h, 1'b1);
				held = 0;
			end else begin
				east_held[held]  = e;
				north_held[held] = n;
				head_held[held]  = h;
				held++;
			end
			return;
		end
		if (held == 3) begin
			queue_point(east_held[0], north_held[0],
				bearing_code(east_held[0], north_held[0], east_held[1], north_held[1]), 1'b0);
			queue_point(east_held[1], north_held[1],
				bearing_code(east_held[0], north_held[0], east_held[2], north_held[2]), 1'b0);
			queue_point(east_held[2], north_held[2],
				bearing_code(east_held[1], north_held[1], e, n), 1'b0);
			east_held[0]  = east_held[2];
			north_held[0] = north_held[2];
		end else begin
			queue_point(east_held[1], north_held[1],
				bearing_code(east_held[0], north_held[0], e, n), 1'b0);
			east_held[0]  = east_held[1];
			north_held[0] = north_held[1];
		end
		if (last) begin
			queue_point(e, n, bearing_code(east_held[0], north_held[0], e, n), 1'b1);
			held = 0;
		end else begin
			east_held[1]  = e;
			north_held[1] = n;
			held = 4;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		point_t want;
		logic   bad;
		if (!arst_n) begin
			expected_pts.delete();
			held = 0;
			pending_r <= 0;
		end else begin
			// outputs first: a result never belongs to a request taken at the same edge
			if (out_ch.valid && out_ch.ready) begin
				if (expected_pts.size() == 0) begin
					$error("output point with nothing outstanding: east_out %0d north_out %0d",
						out_ch.east_out, out_ch.north_out);
					fail_count++;
				end else begin
					want = expected_pts.pop_front();
					bad  = 1'b0;
					if (out_ch.east_out !== want.east) begin
						$error("east_out: expected %0d, got %0d", want.east, out_ch.east_out);
						bad = 1'b1;
					end
					if (out_ch.north_out !== want.north) begin
						$error("north_out: expected %0d, got %0d", want.north, out_ch.north_out);
						bad = 1'b1;
					end
					if (out_ch.heading_out !== want.heading) begin
						$error("heading_out: expected %0d, got %0d", want.heading,
							out_ch.heading_out);
						bad = 1'b1;
					end
					if (out_ch.out_last !== want.last) begin
						$error("out_last: expected %0d, got %0d", want.last, out_ch.out_last);
						bad = 1'b1;
					end
					if (bad)
						fail_count++;
				end
			end
			if (in_ch.valid && in_ch.ready)
				track_point(in_ch.east_pos, in_ch.north_pos, in_ch.heading_in, in_ch.path_end);
			pending_r <= expected_pts.size();
		end
	end

endmodule

[tb/testbench.sv]
// Top of the polyline heading estimator test: clock, reset, point stimulus,
// output back-pressure and the verdict. Depends on pehe_pkg, the two channel
// interfaces, polyline_heading_estimator and pehe_checker.

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import pehe_pkg::*;

	localparam int N_ITEMS     = 400;
	localparam int QUIET_TAIL  = 60;
	localparam int HOLD_CYCLES = 300;
	localparam int LIMIT       = 400000;
	localparam coord_t C_MAX   = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam coord_t C_MIN   = {1'b1, {(COORD_WIDTH-1){1'b0}}};

	typedef enum int {
		WALK,
		SCATTER,
		CORNERS,
		CREEP
	} path_style_t;

	logic clk;
	logic arst_n;
	int   fails;
	int   pending;
	int   sent = 0;
	int   cycles = 0;
	int   stall_left = 0;
	logic quiet = 1'b0;
	logic hold_go = 1'b0;
	logic long_hold = 1'b0;

	pehe_in_if  in_ch();
	pehe_out_if out_ch();

	polyline_heading_estimator u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	pehe_checker u_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.fails   (fails),
		.pending (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Some tests failed");
		$finish;
	end

	// receiver: random stall bursts, none in the quiet tail
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold) begin
				out_ch.ready <= 1'b0;
			end else if (stall_left != 0) begin
				out_ch.ready <= 1'b0;
				stall_left--;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				out_ch.ready <= 1'b0;
				stall_left = $urandom_range(0, 5);
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// one long hold-off so the block backs up into the input
	initial begin
		wait (hold_go);
		@(posedge clk);
		long_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		long_hold <= 1'b0;
	end

	task automatic offer(input coord_t e, input coord_t n, input heading_t h, input logic last);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_ch.valid      <= 1'b1;
		in_ch.east_pos   <= e;
		in_ch.north_pos  <= n;
		in_ch.heading_in <= h;
		in_ch.path_end   <= last;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		sent++;
	endtask

	function automatic coord_t step_coord(input coord_t prev, input path_style_t style);
		coord_t mag;
		mag = coord_t'($urandom & ((32'd1 << $urandom_range(0, 24)) - 32'd1));
		case (style)
			WALK:    return $urandom_range(0, 1) ? prev + mag : prev - mag;
			SCATTER: return coord_t'($urandom);
			CORNERS: begin
				case ($urandom_range(0, 4))
					0:       return C_MIN;
					1:       return C_MAX;
					2:       return '0;
					3:       return '1;
					default: return prev;
				endcase
			end
			default: return ($urandom_range(0, 3) == 0) ? prev : prev + mag;
		endcase
	endfunction

	task automatic send_path(input int len);
		coord_t      e, n;
		path_style_t style;
		int          k;
		style = path_style_t'($urandom_range(0, 3));
		e = coord_t'($urandom);
		n = coord_t'($urandom);
		for (k = 0; k < len; k++) begin
			if (k != 0) begin
				e = step_coord(e, style);
				n = step_coord(n, style);
			end
			offer(e, n, heading_t'($urandom), k == len - 1);
		end
	endtask

	initial begin
		int  len;
		logic drained;
		drained          = 1'b0;
		in_ch.valid      = 1'b0;
		in_ch.east_pos   = '0;
		in_ch.north_pos  = '0;
		in_ch.heading_in = '0;
		in_ch.path_end   = 1'b0;
		arst_n           = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// paths of one, two and three points pass through untouched
		offer(C_MAX, C_MIN, '1, 1'b1);
		offer(C_MIN, C_MAX, '0, 1'b0);
		offer('0, '0, 16'h1234, 1'b1);
		offer(-1, -1, 16'h8000, 1'b0);
		offer(1, 1, 16'h7fff, 1'b0);
		offer(C_MAX, C_MAX, '1, 1'b1);
		// repeated point: zero difference everywhere
		repeat (3) offer(1000, -1000, 16'h00ff, 1'b0);
		offer(1000, -1000, 16'hff00, 1'b1);
		// full-range differences, due north/south/east/west, near-full-turn rounding
		offer(C_MIN, C_MIN, 16'h0001, 1'b0);
		offer(C_MAX, C_MAX, 16'h0002, 1'b0);
		offer(C_MIN, C_MAX, 16'h0004, 1'b0);
		offer(C_MAX, C_MIN, 16'h0008, 1'b0);
		offer(C_MAX, C_MIN + 5, 16'h0010, 1'b0);
		offer('0, '0, 16'h0020, 1'b0);
		offer('0, '0, 16'h0040, 1'b0);
		offer(1, '0, 16'h0080, 1'b0);
		offer(-1, '0, 16'h0100, 1'b0);
		offer('0, 32'sd1 << 30, 16'h0200, 1'b0);
		offer('0, 32'sd1 << 30, 16'h0400, 1'b1);

		while (sent < N_ITEMS) begin
			if (sent >= 120)
				hold_go <= 1'b1;
			if (!drained && sent >= 230) begin
				// let every outstanding point come out before going on
				in_ch.valid <= 1'b0;
				do @(posedge clk); while (pending != 0);
				drained = 1'b1;
			end
			if (sent >= N_ITEMS - QUIET_TAIL)
				quiet <= 1'b1;
			case ($urandom_range(0, 9))
				0:       len = $urandom_range(1, 3);
				1:       len = $urandom_range(30, 50);
				default: len = $urandom_range(4, 12);
			endcase
			send_path(len);
		end
		in_ch.valid <= 1'b0;

		do @(posedge clk); while (pending != 0);
		repeat (40) @(posedge clk);
		if (fails == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
